@@ hdl/obo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obo_pkg
// Shared types, constants and helpers for the oriented box overlap test.
// ----------------------------------------------------------------------------
package obo_pkg;

  localparam int unsigned DX_W  = 48;  // corner offset, reference units times 2^14
  localparam int unsigned LW    = 64;  // local corner coordinate, units times 2^28
  localparam int unsigned WQ_W  = 36;  // rotated contact sum after the 2^28 floor
  localparam int unsigned CNT_W = 3;

  localparam logic signed [15:0] AXIS_ONE = 16'sd16384;
  // Reciprocal of three for 36-bit operands: ceil(2^38 / 3).
  localparam logic [36:0] RECIP3 = 37'd91625968982;
  // Offset that makes a contact term nonnegative and is a multiple of three.
  localparam logic [36:0] DIV3_BIAS = 37'd51539607552;
  localparam logic signed [WQ_W-1:0] DIV3_UNBIAS = 36'sd17179869184;

  typedef logic signed [LW-1:0]   obo_wide_t;
  typedef logic signed [DX_W-1:0] obo_dx_t;

  typedef enum logic [2:0] {
    CFG_CENTRE_X    = 3'd0,
    CFG_CENTRE_Y    = 3'd1,
    CFG_AXIS_COS    = 3'd2,
    CFG_AXIS_SIN    = 3'd3,
    CFG_HALF_WIDTH  = 3'd4,
    CFG_HALF_HEIGHT = 3'd5
  } obo_cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] other_centre_x;
    logic signed [31:0] other_centre_y;
    logic signed [15:0] other_axis_cos;
    logic signed [15:0] other_axis_sin;
    logic [30:0]        other_half_width;
    logic [30:0]        other_half_height;
    logic [30:0]        prior_penetration;
  } obo_in_t;

  typedef struct packed {
    logic               contact_found;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic               improved;
    logic [30:0]        penetration_out;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
  } obo_out_t;

  // Reference box with its axes already clamped.
  typedef struct packed {
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [15:0] rc;
    logic signed [15:0] rs;
    logic [30:0]        half_w;
    logic [30:0]        half_h;
  } obo_geom_t;

  typedef struct packed {
    logic                 valid;
    obo_wide_t [3:0]      lx;
    obo_wide_t [3:0]      ly;
    logic [30:0]          prior;
  } obo_corner_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    obo_wide_t        mnx;
    obo_wide_t        mxx;
    obo_wide_t        mny;
    obo_wide_t        mxy;
    obo_wide_t        sumx;
    obo_wide_t        sumy;
    logic [CNT_W-1:0] cnt;
    logic [30:0]      prior;
  } obo_ext_t;

  function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] a);
    logic signed [15:0] r;
    if (a > AXIS_ONE) begin
      r = AXIS_ONE;
    end else if (a < -AXIS_ONE) begin
      r = -AXIS_ONE;
    end else begin
      r = a;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic obo_wide_t half_to_wide(input logic [30:0] h);
    return obo_wide_t'({5'b0, h, 28'b0});
  endfunction

endpackage

@@ hdl/oriented_box_overlap_test_core.sv @@
`timescale 1ns / 1ps
// One result word per box pair, flagged by result_valid_o.
// Throughput: one box pair per cycle; busy is never raised, since the nine
// register stages hold no state between words.
// Reset: asynchronous, active low; clears the stage valid bits and loads the
// reference box with centre 0, cos 16384, sin 0 and zero half extents.
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_core
// Corner penetration test of a stream of oriented boxes against a configured
// reference box.
// ----------------------------------------------------------------------------
module oriented_box_overlap_test_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  obo_pkg::obo_in_t  item_i,
  output logic              result_valid_o,
  output obo_pkg::obo_out_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  logic signed [31:0] centre_x_q, centre_y_q;
  logic signed [15:0] cos_q, sin_q;
  logic [30:0]        half_w_q, half_h_q;
  obo_pkg::obo_geom_t geom;
  obo_pkg::obo_corner_t corner;
  obo_pkg::obo_ext_t    ext;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      cos_q      <= obo_pkg::AXIS_ONE;
      sin_q      <= '0;
      half_w_q   <= '0;
      half_h_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        obo_pkg::CFG_CENTRE_X:    centre_x_q <= cfg_data_i;
        obo_pkg::CFG_CENTRE_Y:    centre_y_q <= cfg_data_i;
        obo_pkg::CFG_AXIS_COS:    cos_q      <= cfg_data_i[15:0];
        obo_pkg::CFG_AXIS_SIN:    sin_q      <= cfg_data_i[15:0];
        obo_pkg::CFG_HALF_WIDTH:  half_w_q   <= cfg_data_i[30:0];
        obo_pkg::CFG_HALF_HEIGHT: half_h_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign geom.centre_x = centre_x_q;
  assign geom.centre_y = centre_y_q;
  assign geom.rc       = obo_pkg::clamp_axis(cos_q);
  assign geom.rs       = obo_pkg::clamp_axis(sin_q);
  assign geom.half_w   = half_w_q;
  assign geom.half_h   = half_h_q;

  obo_corners u_corners (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .item_i   (item_i),
    .geom_i   (geom),
    .corner_o (corner)
  );

  obo_extent u_extent (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .corner_i (corner),
    .geom_i   (geom),
    .ext_o    (ext)
  );

  obo_resolve u_resolve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ext_i    (ext),
    .geom_i   (geom),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

@@ hdl/obo_corners.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obo_corners
// Four pipeline stages that place the tested box's corners in the reference
// frame, exactly, at 28 extra fraction bits.
// ----------------------------------------------------------------------------
module obo_corners (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  obo_pkg::obo_in_t  item_i,
  input  obo_pkg::obo_geom_t geom_i,
  output obo_pkg::obo_corner_t corner_o
);

  // Stage 1: centre offset and the four half-extent products.
  logic               v1_q;
  obo_pkg::obo_dx_t   dx0_q, dy0_q, a_q, b_q, c_q, d_q;
  logic [30:0]        prior1_q;
  logic signed [32:0] ddx, ddy;
  logic signed [15:0] oc, os;
  obo_pkg::obo_dx_t   a_d, b_d, c_d, d_d;

  assign oc  = obo_pkg::clamp_axis(item_i.other_axis_cos);
  assign os  = obo_pkg::clamp_axis(item_i.other_axis_sin);
  assign ddx = {item_i.other_centre_x[31], item_i.other_centre_x}
             - {geom_i.centre_x[31], geom_i.centre_x};
  assign ddy = {item_i.other_centre_y[31], item_i.other_centre_y}
             - {geom_i.centre_y[31], geom_i.centre_y};
  assign a_d = $signed({1'b0, item_i.other_half_width})  * oc;
  assign b_d = $signed({1'b0, item_i.other_half_height}) * os;
  assign c_d = $signed({1'b0, item_i.other_half_width})  * os;
  assign d_d = $signed({1'b0, item_i.other_half_height}) * oc;

  always_ff @(posedge clk_i) begin
    dx0_q    <= {ddx[32], ddx, 14'b0};
    dy0_q    <= {ddy[32], ddy, 14'b0};
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    d_q      <= d_d;
    prior1_q <= item_i.prior_penetration;
  end

  // Stage 2: corner offsets in world orientation.
  logic                        v2_q;
  obo_pkg::obo_dx_t [3:0]      dx_q, dy_q;
  obo_pkg::obo_dx_t [3:0]      dx_d, dy_d;
  logic [30:0]                 prior2_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dx_d[i] = dx0_q + ((i & 2) != 0 ? a_q : -a_q) - ((i & 1) != 0 ? b_q : -b_q);
      dy_d[i] = dy0_q + ((i & 2) != 0 ? c_q : -c_q) + ((i & 1) != 0 ? d_q : -d_q);
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    prior2_q <= prior1_q;
  end

  // Stage 3: projections onto the reference axes.
  logic                     v3_q;
  obo_pkg::obo_wide_t [3:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic [30:0]              prior3_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      pxc_q[i] <= dx_q[i] * geom_i.rc;
      pys_q[i] <= dy_q[i] * geom_i.rs;
      pyc_q[i] <= dy_q[i] * geom_i.rc;
      pxs_q[i] <= dx_q[i] * geom_i.rs;
    end
    prior3_q <= prior2_q;
  end

  // Stage 4: local coordinates.
  logic                     v4_q;
  obo_pkg::obo_wide_t [3:0] lx_q, ly_q;
  logic [30:0]              prior4_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      lx_q[i] <= pxc_q[i] + pys_q[i];
      ly_q[i] <= pyc_q[i] - pxs_q[i];
    end
    prior4_q <= prior3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign corner_o.valid = v4_q;
  assign corner_o.lx    = lx_q;
  assign corner_o.ly    = ly_q;
  assign corner_o.prior = prior4_q;

endmodule

@@ hdl/obo_extent.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obo_extent
// One stage: local bounds of the corners, the inside test, the inside count
// and sums, and the overlap decision.
// ----------------------------------------------------------------------------
module obo_extent (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  obo_pkg::obo_corner_t corner_i,
  input  obo_pkg::obo_geom_t   geom_i,
  output obo_pkg::obo_ext_t    ext_o
);

  obo_pkg::obo_wide_t ex, ey;
  obo_pkg::obo_wide_t mnx_a, mnx_b, mxx_a, mxx_b, mny_a, mny_b, mxy_a, mxy_b;
  obo_pkg::obo_wide_t mnx, mxx, mny, mxy, sumx, sumy;
  logic [3:0]         in_box;
  logic [obo_pkg::CNT_W-1:0] cnt;
  logic               hit;
  obo_pkg::obo_ext_t  ext_d, ext_q;

  assign ex = obo_pkg::half_to_wide(geom_i.half_w);
  assign ey = obo_pkg::half_to_wide(geom_i.half_h);

  always_comb begin
    mnx_a = (corner_i.lx[1] < corner_i.lx[0]) ? corner_i.lx[1] : corner_i.lx[0];
    mnx_b = (corner_i.lx[3] < corner_i.lx[2]) ? corner_i.lx[3] : corner_i.lx[2];
    mxx_a = (corner_i.lx[1] > corner_i.lx[0]) ? corner_i.lx[1] : corner_i.lx[0];
    mxx_b = (corner_i.lx[3] > corner_i.lx[2]) ? corner_i.lx[3] : corner_i.lx[2];
    mny_a = (corner_i.ly[1] < corner_i.ly[0]) ? corner_i.ly[1] : corner_i.ly[0];
    mny_b = (corner_i.ly[3] < corner_i.ly[2]) ? corner_i.ly[3] : corner_i.ly[2];
    mxy_a = (corner_i.ly[1] > corner_i.ly[0]) ? corner_i.ly[1] : corner_i.ly[0];
    mxy_b = (corner_i.ly[3] > corner_i.ly[2]) ? corner_i.ly[3] : corner_i.ly[2];
    mnx = (mnx_b < mnx_a) ? mnx_b : mnx_a;
    mxx = (mxx_b > mxx_a) ? mxx_b : mxx_a;
    mny = (mny_b < mny_a) ? mny_b : mny_a;
    mxy = (mxy_b > mxy_a) ? mxy_b : mxy_a;

    sumx = '0;
    sumy = '0;
    cnt  = '0;
    for (int i = 0; i < 4; i++) begin
      in_box[i] = (corner_i.lx[i] >= -ex) && (corner_i.lx[i] <= ex)
               && (corner_i.ly[i] >= -ey) && (corner_i.ly[i] <= ey);
      if (in_box[i]) begin
        sumx = sumx + corner_i.lx[i];
        sumy = sumy + corner_i.ly[i];
        cnt  = cnt + 3'd1;
      end
    end

    hit = !((mxx <= -ex) || (mnx >= ex) || (mxy <= -ey) || (mny >= ey)) && (cnt != '0);

    ext_d.valid = corner_i.valid;
    ext_d.hit   = hit;
    ext_d.mnx   = mnx;
    ext_d.mxx   = mxx;
    ext_d.mny   = mny;
    ext_d.mxy   = mxy;
    ext_d.sumx  = sumx;
    ext_d.sumy  = sumy;
    ext_d.cnt   = cnt;
    ext_d.prior = corner_i.prior;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= '0;
    end else begin
      ext_q <= ext_d;
    end
  end

  assign ext_o = ext_q;

endmodule

@@ hdl/obo_resolve.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obo_resolve
// Four stages: averaged world contact (rotate back, divide by the inside
// count) and the penetration candidate search, then the result register.
// ----------------------------------------------------------------------------
module obo_resolve (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  obo_pkg::obo_ext_t  ext_i,
  input  obo_pkg::obo_geom_t geom_i,
  output logic               valid_o,
  output obo_pkg::obo_out_t  result_o
);

  localparam int unsigned WQ = obo_pkg::WQ_W;

  obo_pkg::obo_wide_t ex, ey;
  assign ex = obo_pkg::half_to_wide(geom_i.half_w);
  assign ey = obo_pkg::half_to_wide(geom_i.half_h);

  // ---------------- Stage 1: rotate products, first two candidates ----------
  logic signed [49:0] tx, ty;
  obo_pkg::obo_wide_t c0, c1, best0, best_a;
  logic signed [15:0] nxa, nya;
  logic               impa;

  assign tx = ext_i.sumx[63:14];
  assign ty = ext_i.sumy[63:14];
  assign c0 = ex - ext_i.mnx;
  assign c1 = ext_i.mxx + ex;
  assign best0 = obo_pkg::obo_wide_t'({5'b0, ext_i.prior, 28'b0});

  always_comb begin
    best_a = best0;
    nxa    = '0;
    nya    = '0;
    impa   = 1'b0;
    if (c0 > 0 && (c0 < best_a || best_a == 0)) begin
      best_a = c0;
      nxa    = geom_i.rc;
      nya    = geom_i.rs;
      impa   = 1'b1;
    end
    if (c1 > 0 && (c1 < best_a || best_a == 0)) begin
      best_a = c1;
      nxa    = -geom_i.rc;
      nya    = -geom_i.rs;
      impa   = 1'b1;
    end
  end

  logic                      v1_q, hit1_q, imp1_q;
  obo_pkg::obo_wide_t        pxc_q, pys_q, pxs_q, pyc_q, c2_q, c3_q, best1_q;
  logic signed [15:0]        nx1_q, ny1_q;
  logic [obo_pkg::CNT_W-1:0] cnt1_q;
  logic [30:0]               prior1_q;

  always_ff @(posedge clk_i) begin
    pxc_q    <= tx * geom_i.rc;
    pys_q    <= ty * geom_i.rs;
    pxs_q    <= tx * geom_i.rs;
    pyc_q    <= ty * geom_i.rc;
    c2_q     <= ey - ext_i.mny;
    c3_q     <= ext_i.mxy + ey;
    best1_q  <= best_a;
    nx1_q    <= nxa;
    ny1_q    <= nya;
    imp1_q   <= impa;
    hit1_q   <= ext_i.hit;
    cnt1_q   <= ext_i.cnt;
    prior1_q <= ext_i.prior;
  end

  // ---------------- Stage 2: world sums, last two candidates ----------------
  obo_pkg::obo_wide_t wx, wy, best_b;
  logic signed [15:0] nxb, nyb;
  logic               impb;

  assign wx = pxc_q - pys_q;
  assign wy = pxs_q + pyc_q;

  always_comb begin
    best_b = best1_q;
    nxb    = nx1_q;
    nyb    = ny1_q;
    impb   = imp1_q;
    if (c2_q > 0 && (c2_q < best_b || best_b == 0)) begin
      best_b = c2_q;
      nxb    = -geom_i.rs;
      nyb    = geom_i.rc;
      impb   = 1'b1;
    end
    if (c3_q > 0 && (c3_q < best_b || best_b == 0)) begin
      best_b = c3_q;
      nxb    = geom_i.rs;
      nyb    = -geom_i.rc;
      impb   = 1'b1;
    end
  end

  logic                      v2_q, hit2_q, imp2_q;
  logic signed [WQ-1:0]      wqx_q, wqy_q;
  obo_pkg::obo_wide_t        best2_q;
  logic signed [15:0]        nx2_q, ny2_q;
  logic [obo_pkg::CNT_W-1:0] cnt2_q;
  logic [30:0]               prior2_q;

  always_ff @(posedge clk_i) begin
    wqx_q    <= wx[63:28];
    wqy_q    <= wy[63:28];
    best2_q  <= best_b;
    nx2_q    <= nxb;
    ny2_q    <= nyb;
    imp2_q   <= impb;
    hit2_q   <= hit1_q;
    cnt2_q   <= cnt1_q;
    prior2_q <= prior1_q;
  end

  // ---------------- Stage 3: divide by count, round penetration -------------
  // A count of three goes through a reciprocal multiply on a biased,
  // nonnegative value, split into two partial products.
  logic [36:0]          vx, vy;
  logic signed [WQ-1:0] qx_d, qy_d;
  logic [64:0]          pen_sum;
  logic [36:0]          pen_q37;
  logic [30:0]          pen_d;

  assign vx = {wqx_q[WQ-1], wqx_q} + obo_pkg::DIV3_BIAS;
  assign vy = {wqy_q[WQ-1], wqy_q} + obo_pkg::DIV3_BIAS;

  always_comb begin
    case (cnt2_q)
      3'd2:    begin qx_d = wqx_q >>> 1; qy_d = wqy_q >>> 1; end
      3'd4:    begin qx_d = wqx_q >>> 2; qy_d = wqy_q >>> 2; end
      default: begin qx_d = wqx_q;       qy_d = wqy_q;       end
    endcase
  end

  assign pen_sum = {1'b0, best2_q} + 65'd268435455;
  assign pen_q37 = pen_sum[64:28];
  assign pen_d   = (pen_q37 > 37'd2147483647) ? 31'h7FFF_FFFF : pen_q37[30:0];

  logic                 v3_q, hit3_q, imp3_q, div3_q;
  logic [54:0]          phx_q, plx_q, phy_q, ply_q;
  logic signed [WQ-1:0] qx_q, qy_q;
  logic [30:0]          pen3_q, prior3_q;
  logic signed [15:0]   nx3_q, ny3_q;

  always_ff @(posedge clk_i) begin
    phx_q    <= vx[36:18] * obo_pkg::RECIP3;
    plx_q    <= vx[17:0]  * obo_pkg::RECIP3;
    phy_q    <= vy[36:18] * obo_pkg::RECIP3;
    ply_q    <= vy[17:0]  * obo_pkg::RECIP3;
    div3_q   <= (cnt2_q == 3'd3);
    qx_q     <= qx_d;
    qy_q     <= qy_d;
    pen3_q   <= pen_d;
    nx3_q    <= nx2_q;
    ny3_q    <= ny2_q;
    imp3_q   <= imp2_q;
    hit3_q   <= hit2_q;
    prior3_q <= prior2_q;
  end

  // ---------------- Stage 4: finish division, add centre, saturate ----------
  logic [72:0]          totx, toty;
  logic signed [WQ-1:0] fx, fy;
  logic signed [36:0]   sx, sy;
  obo_pkg::obo_out_t    res_d, res_q;
  logic                 v4_q;

  assign totx = {phx_q, 18'b0} + {18'b0, plx_q};
  assign toty = {phy_q, 18'b0} + {18'b0, ply_q};
  assign fx = div3_q ? ($signed({1'b0, totx[72:38]}) - obo_pkg::DIV3_UNBIAS) : qx_q;
  assign fy = div3_q ? ($signed({1'b0, toty[72:38]}) - obo_pkg::DIV3_UNBIAS) : qy_q;
  assign sx = {{5{geom_i.centre_x[31]}}, geom_i.centre_x} + {fx[WQ-1], fx};
  assign sy = {{5{geom_i.centre_y[31]}}, geom_i.centre_y} + {fy[WQ-1], fy};

  always_comb begin
    res_d                 = '0;
    res_d.penetration_out = prior3_q;
    if (hit3_q) begin
      res_d.contact_found = 1'b1;
      res_d.contact_x     = obo_pkg::sat32(sx);
      res_d.contact_y     = obo_pkg::sat32(sy);
      if (imp3_q) begin
        res_d.improved        = 1'b1;
        res_d.penetration_out = pen3_q;
        res_d.normal_x        = nx3_q;
        res_d.normal_y        = ny3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= ext_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign valid_o  = v4_q;
  assign result_o = res_q;

endmodule
